@@ hw/rtl/twdl_pkg.sv @@
// shared types and constants of the timing wheel with delta-coded slot lists
// no dependencies; used by timer_wheel_delta_lists_core
package twdl_pkg;

    localparam int SLOTS      = 32;
    localparam int SLOT_W     = 5;
    localparam int MAX_TIMERS = 64;
    localparam int ID_W       = 6;
    localparam int LINK_W     = 7;
    localparam int ROLL_W     = 27;
    localparam int FUNC_W     = 3;
    localparam int DATA_W     = 32;
    localparam int CNT_W      = 7;
    localparam int SCAN_W     = 6;

    localparam logic [LINK_W-1:0] NIL             = LINK_W'(MAX_TIMERS);
    localparam logic [ROLL_W-1:0] ROLL_MAX        = '1;
    localparam logic [DATA_W-1:0] MAX_TIMEOUT_RST = 32'd4294967262;
    localparam logic [DATA_W-1:0] NONE_FOUND      = '1;

    localparam logic [FUNC_W-1:0] F_ADD    = 3'd0;
    localparam logic [FUNC_W-1:0] F_DEL    = 3'd1;
    localparam logic [FUNC_W-1:0] F_NEXT   = 3'd2;
    localparam logic [FUNC_W-1:0] F_TARGET = 3'd3;
    localparam logic [FUNC_W-1:0] F_SLEEP  = 3'd4;

    typedef struct packed {
        logic [LINK_W-1:0] nxt;
        logic [LINK_W-1:0] prv;
        logic [SLOT_W-1:0] slot;
        logic [ROLL_W-1:0] roll;
    } t_entry;

    typedef enum logic [4:0] {
        S_IDLE, S_DISP,
        S_U_GOT_ID, S_U_GOT_NX, S_U_PV, S_U_GOT_PV, S_U_END,
        S_I_PREP, S_I_ROLL, S_I_WALK, S_I_CHK, S_I_LNK, S_I_LNK_E, S_I_LNK_L,
        S_NE, S_NE_OUT,
        S_T_GOT_ID, S_T_WALK, S_T_CHK, S_T_OUT,
        S_SL, S_DONE
    } t_state;

    function automatic logic is_nil(input logic [LINK_W-1:0] l);
        return l[LINK_W-1];
    endfunction

    // (rolls - 1) * SLOTS + distance, distance 0 read as SLOTS
    function automatic logic [DATA_W-1:0] expire_of(input logic [DATA_W-1:0] rolls,
                                                    input logic [SLOT_W-1:0] slot,
                                                    input logic [SLOT_W-1:0] cur);
        logic [SLOT_W-1:0] d;
        logic [DATA_W-1:0] span;
        d    = slot - cur;
        span = (d == '0) ? DATA_W'(SLOTS) : DATA_W'(d);
        return ((rolls - 32'd1) << SLOT_W) + span;
    endfunction

endpackage

@@ hw/rtl/twdl_ram.sv @@
// single write port, single read port synchronous ram, registered read data
// no dependencies
module twdl_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 46
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

@@ hw/rtl/timer_wheel_delta_lists_core.sv @@
// timing wheel with delta-coded slot lists: sequencer, slot heads, timer entry ram
// depends on twdl_pkg and twdl_ram
//
// usage: drive i_func, i_timer_id, i_ticks and raise start while busy is low; the
// request is taken at that edge and busy stays high until it is done. exactly one
// result per request appears on o_expire_time, o_found, o_status for one cycle,
// marked by o_strobe, in the cycle busy falls. the receiver cannot stall, so no
// result is ever held. max_timeout is written over i_cfg_data with i_cfg_valid,
// o_cfg_ready while idle.
// the single read port of the timer entry ram reads list entries one at a time
// (k = list entries passed or ahead of the timer):
//   delete: if armed, the timer is unlinked (successor, predecessor rewritten)
//   add: walks k entries, stopping at a later entry or at the end of the list;
//        when the timer was armed it is unlinked first
//   next expire: one slot head per cycle, pipelined reads
//   target expire: if armed, walks the k entries ahead of the timer
//   sleep update: rewrites each non-empty slot head, nothing for zero ticks
// reset (synchronous, i_rst_n low) empties all slots, disarms all timers, sets the
// cursor to 0 and max_timeout to 4294967262; no clearing pass is needed.
module timer_wheel_delta_lists_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [twdl_pkg::FUNC_W-1:0]   i_func,
    input  logic [twdl_pkg::ID_W-1:0]     i_timer_id,
    input  logic [twdl_pkg::DATA_W-1:0]   i_ticks,
    output logic                          o_strobe,
    output logic [twdl_pkg::DATA_W-1:0]   o_expire_time,
    output logic                          o_found,
    output logic                          o_status,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [twdl_pkg::DATA_W-1:0]   i_cfg_data
);

    import twdl_pkg::*;

    t_state r_state, n_state;

    logic [FUNC_W-1:0] r_func;
    logic [ID_W-1:0]   r_id;
    logic [DATA_W-1:0] r_ticks, n_ticks;
    logic [DATA_W-1:0] r_max;
    logic [SLOT_W-1:0] r_cur, n_cur;
    logic [LINK_W-1:0] r_head [SLOTS];
    logic [MAX_TIMERS-1:0] r_active;

    logic [SLOT_W-1:0] r_slot, n_slot;
    logic [ROLL_W-1:0] r_roll, n_roll;
    logic [LINK_W-1:0] r_e, n_e, r_last, n_last, r_nx, n_nx, r_pv, n_pv;
    logic [CNT_W-1:0]  r_n, n_n;
    t_entry            r_ew, n_ew, r_lw, n_lw;
    logic [ROLL_W-1:0] r_rid, n_rid;
    logic [DATA_W-1:0] r_sum, n_sum;
    logic [SCAN_W-1:0] r_i, n_i;
    logic              r_pend, n_pend;
    logic [SLOT_W-1:0] r_pslot, n_pslot;
    logic [ID_W-1:0]   r_ph, n_ph;
    logic [SLOT_W-1:0] r_pi, n_pi;
    logic [ROLL_W-1:0] r_best, n_best;
    logic [SLOT_W-1:0] r_bslot, n_bslot;
    logic              r_have, n_have;
    logic [SCAN_W-1:0] r_idx, n_idx;
    logic [ROLL_W-1:0] r_sub, n_sub;
    logic [DATA_W-1:0] r_exp, n_exp;
    logic              r_found, n_found, r_status, n_status, r_strobe, n_strobe;

    // ram and side-array controls
    logic              mem_we;
    logic [ID_W-1:0]   mem_wa, mem_ra;
    t_entry            mem_wd, rd;
    logic [$bits(t_entry)-1:0] mem_rdata;
    logic [SLOT_W-1:0] hd_ra, hd_wa;
    logic [LINK_W-1:0] hd, hd_wd;
    logic              hd_we, act_set, act_clr;

    // scratch
    logic [DATA_W-1:0] q32, tm1;
    logic [DATA_W:0]   r33;
    logic [SLOT_W-1:0] idx5, sc;
    logic              dec;

    twdl_ram #(.DEPTH(MAX_TIMERS), .WIDTH($bits(t_entry))) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_wa),
        .i_wdata (mem_wd),
        .i_raddr (mem_ra),
        .o_rdata (mem_rdata)
    );

    assign rd            = t_entry'(mem_rdata);
    assign hd            = r_head[hd_ra];
    assign busy          = (r_state != S_IDLE);
    assign o_cfg_ready   = ~busy;
    assign o_strobe      = r_strobe;
    assign o_expire_time = r_exp;
    assign o_found       = r_found;
    assign o_status      = r_status;

    always_comb begin
        n_state = r_state;
        n_ticks = r_ticks;  n_cur = r_cur;    n_slot = r_slot;   n_roll = r_roll;
        n_e = r_e;          n_last = r_last;  n_nx = r_nx;       n_pv = r_pv;
        n_n = r_n;          n_ew = r_ew;      n_lw = r_lw;       n_rid = r_rid;
        n_sum = r_sum;      n_i = r_i;        n_pend = r_pend;   n_pslot = r_pslot;
        n_ph = r_ph;        n_pi = r_pi;      n_best = r_best;   n_bslot = r_bslot;
        n_have = r_have;    n_idx = r_idx;    n_sub = r_sub;
        n_exp = r_exp;      n_found = r_found; n_status = r_status;
        n_strobe = 1'b0;
        mem_we = 1'b0;  mem_wa = r_id;  mem_wd = rd;  mem_ra = r_id;
        hd_ra = r_slot; hd_we = 1'b0;   hd_wa = r_slot; hd_wd = NIL;
        act_set = 1'b0; act_clr = 1'b0;
        q32  = r_ticks >> SLOT_W;
        idx5 = r_ticks[SLOT_W-1:0];
        r33  = {1'b0, q32} + (DATA_W+1)'(idx5 != '0);
        tm1  = r_ticks - 32'd1;
        sc   = r_cur + r_i[SLOT_W-1:0];
        dec  = (r_pi != '0) && ({1'b0, r_pi} < r_idx);

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                n_exp = '0; n_found = 1'b0; n_status = 1'b0;
                n_i = '0; n_pend = 1'b0; n_have = 1'b0;
                case (r_func)
                    F_ADD: begin
                        n_state = r_active[r_id] ? S_U_GOT_ID : S_I_PREP;
                    end
                    F_DEL: begin
                        if (r_active[r_id]) begin
                            n_state = S_U_GOT_ID;
                        end else begin
                            n_status = 1'b1;
                            n_state  = S_DONE;
                        end
                    end
                    F_NEXT: begin
                        n_state = S_NE;
                    end
                    F_TARGET: begin
                        if (r_active[r_id]) begin
                            n_state = S_T_GOT_ID;
                        end else begin
                            n_exp   = NONE_FOUND;
                            n_state = S_DONE;
                        end
                    end
                    F_SLEEP: begin
                        if (r_ticks == '0) begin
                            n_state = S_DONE;
                        end else begin
                            if (idx5 == '0) begin
                                n_idx = SCAN_W'(SLOTS);
                                n_sub = ROLL_W'(q32 - 32'd1);
                            end else begin
                                n_idx = SCAN_W'(idx5);
                                n_sub = q32[ROLL_W-1:0];
                            end
                            n_state = S_SL;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            // unlink: successor takes our rolls, predecessor or head skips us
            S_U_GOT_ID: begin
                n_nx = rd.nxt; n_pv = rd.prv; n_slot = rd.slot; n_rid = rd.roll;
                mem_ra = rd.nxt[ID_W-1:0];
                n_state = is_nil(rd.nxt) ? S_U_PV : S_U_GOT_NX;
            end
            S_U_GOT_NX: begin
                mem_we = 1'b1;
                mem_wa = r_nx[ID_W-1:0];
                mem_wd = rd;
                mem_wd.roll = rd.roll + r_rid;
                mem_wd.prv  = r_pv;
                n_state = S_U_PV;
            end
            S_U_PV: begin
                mem_ra = r_pv[ID_W-1:0];
                if (is_nil(r_pv)) begin
                    hd_we = 1'b1; hd_wa = r_slot; hd_wd = r_nx;
                    n_state = S_U_END;
                end else begin
                    n_state = S_U_GOT_PV;
                end
            end
            S_U_GOT_PV: begin
                mem_we = 1'b1;
                mem_wa = r_pv[ID_W-1:0];
                mem_wd = rd;
                mem_wd.nxt = r_nx;
                n_state = S_U_END;
            end
            S_U_END: begin
                act_clr = 1'b1;
                n_state = (r_func == F_ADD) ? S_I_PREP : S_DONE;
            end
            S_I_PREP: begin
                n_ticks = (r_ticks > r_max) ? r_max : r_ticks;
                n_state = S_I_ROLL;
            end
            S_I_ROLL: begin
                n_roll = (r33 > (DATA_W+1)'(ROLL_MAX)) ? ROLL_MAX : r33[ROLL_W-1:0];
                n_slot = idx5 + r_cur;
                hd_ra  = idx5 + r_cur;
                n_e    = hd;
                n_last = NIL;
                n_n    = '0;
                n_state = S_I_WALK;
            end
            S_I_WALK: begin
                mem_ra = r_e[ID_W-1:0];
                if (r_n == CNT_W'(MAX_TIMERS)) begin
                    n_e = NIL;
                    n_state = S_I_LNK;
                end else if (is_nil(r_e)) begin
                    n_state = S_I_LNK;
                end else begin
                    n_state = S_I_CHK;
                end
            end
            S_I_CHK: begin
                if (rd.roll <= r_roll) begin
                    n_roll = r_roll - rd.roll;
                    n_last = r_e;
                    n_lw   = rd;
                    n_e    = rd.nxt;
                    n_n    = r_n + 1'b1;
                    n_state = S_I_WALK;
                end else begin
                    n_ew = rd;
                    n_ew.roll = rd.roll - r_roll;
                    n_state = S_I_LNK;
                end
            end
            S_I_LNK: begin
                mem_we = 1'b1;
                mem_wa = r_id;
                mem_wd = '{nxt: r_e, prv: r_last, slot: r_slot, roll: r_roll};
                act_set = 1'b1;
                n_state = S_I_LNK_E;
            end
            S_I_LNK_E: begin
                mem_we = !is_nil(r_e);
                mem_wa = r_e[ID_W-1:0];
                mem_wd = r_ew;
                mem_wd.prv = {1'b0, r_id};
                n_state = S_I_LNK_L;
            end
            S_I_LNK_L: begin
                if (is_nil(r_last)) begin
                    hd_we = 1'b1; hd_wa = r_slot; hd_wd = {1'b0, r_id};
                end else begin
                    mem_we = 1'b1;
                    mem_wa = r_last[ID_W-1:0];
                    mem_wd = r_lw;
                    mem_wd.nxt = {1'b0, r_id};
                end
                n_state = S_DONE;
            end
            // one slot head issued per cycle, its roll checked the cycle after
            S_NE: begin
                if (r_pend && (!r_have || rd.roll < r_best)) begin
                    n_have = 1'b1; n_best = rd.roll; n_bslot = r_pslot;
                end
                hd_ra  = sc + 1'b1;
                mem_ra = hd[ID_W-1:0];
                if (r_i == SCAN_W'(SLOTS)) begin
                    n_pend  = 1'b0;
                    n_state = S_NE_OUT;
                end else begin
                    n_pend  = !is_nil(hd);
                    n_pslot = sc + 1'b1;
                    n_i     = r_i + 1'b1;
                end
            end
            S_NE_OUT: begin
                n_found = r_have;
                n_exp   = r_have ? expire_of(DATA_W'(r_best), r_bslot, r_cur) : NONE_FOUND;
                n_state = S_DONE;
            end
            S_T_GOT_ID: begin
                n_slot = rd.slot;
                n_sum  = DATA_W'(rd.roll);
                hd_ra  = rd.slot;
                n_e    = hd;
                n_n    = '0;
                n_state = S_T_WALK;
            end
            S_T_WALK: begin
                mem_ra = r_e[ID_W-1:0];
                if (is_nil(r_e) || r_e == {1'b0, r_id} || r_n == CNT_W'(MAX_TIMERS)) begin
                    n_state = S_T_OUT;
                end else begin
                    n_state = S_T_CHK;
                end
            end
            S_T_CHK: begin
                n_sum = r_sum + DATA_W'(rd.roll);
                n_e   = rd.nxt;
                n_n   = r_n + 1'b1;
                n_state = S_T_WALK;
            end
            S_T_OUT: begin
                n_found = 1'b1;
                n_exp   = expire_of(r_sum, r_slot, r_cur);
                n_state = S_DONE;
            end
            // write back the previous head while the next one is read
            S_SL: begin
                if (r_pend) begin
                    mem_we = 1'b1;
                    mem_wa = r_ph;
                    mem_wd = rd;
                    mem_wd.roll = rd.roll - r_sub - ROLL_W'(dec);
                end
                hd_ra  = sc;
                mem_ra = hd[ID_W-1:0];
                if (r_i == SCAN_W'(SLOTS)) begin
                    n_pend  = 1'b0;
                    n_cur   = r_cur + tm1[SLOT_W-1:0];
                    n_state = S_DONE;
                end else begin
                    n_pend = !is_nil(hd);
                    n_ph   = hd[ID_W-1:0];
                    n_pi   = r_i[SLOT_W-1:0];
                    n_i    = r_i + 1'b1;
                end
            end
            S_DONE: begin
                n_strobe = 1'b1;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur    <= '0;
            r_max    <= MAX_TIMEOUT_RST;
            r_active <= '0;
            r_strobe <= 1'b0;
            for (int k = 0; k < SLOTS; k++) begin
                r_head[k] <= NIL;
            end
        end else begin
            r_cur    <= n_cur;
            r_strobe <= n_strobe;
            if (i_cfg_valid && o_cfg_ready) begin
                r_max <= i_cfg_data;
            end
            if (hd_we) begin
                r_head[hd_wa] <= hd_wd;
            end
            if (act_set) begin
                r_active[r_id] <= 1'b1;
            end else if (act_clr) begin
                r_active[r_id] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_func  <= i_func;
            r_id    <= i_timer_id;
            r_ticks <= i_ticks;
        end else begin
            r_ticks <= n_ticks;
        end
        r_slot <= n_slot;  r_roll <= n_roll;  r_e <= n_e;        r_last <= n_last;
        r_nx <= n_nx;      r_pv <= n_pv;      r_n <= n_n;        r_ew <= n_ew;
        r_lw <= n_lw;      r_rid <= n_rid;    r_sum <= n_sum;    r_i <= n_i;
        r_pend <= n_pend;  r_pslot <= n_pslot; r_ph <= n_ph;     r_pi <= n_pi;
        r_best <= n_best;  r_bslot <= n_bslot; r_have <= n_have; r_idx <= n_idx;
        r_sub <= n_sub;    r_exp <= n_exp;    r_found <= n_found; r_status <= n_status;
    end

    a_strobe_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_state == S_DONE))
        else $error("result strobe without a finished request");

    a_busy_falls_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_strobe)
        else $error("request ended without a result");

    a_link_unarmed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_I_LNK) |-> !r_active[r_id])
        else $error("insert of a timer still on a list");

    a_found_only_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_found) |-> (r_func == F_NEXT || r_func == F_TARGET))
        else $error("found flag on a non-query request");

endmodule
